@@ hdl/flac_pkg.sv @@
`timescale 1ns / 1ps

package flac_pkg;

    // flash geometry
    localparam int FLASH_LOG2  = 24;
    localparam int SECTOR_LOG2 = 12;
    localparam int WORD_LOG2   = 2;
    localparam int SECTOR_W    = FLASH_LOG2 - SECTOR_LOG2;
    localparam int SLOT_W      = SECTOR_LOG2 - WORD_LOG2;
    localparam int SLOTS_PER_SECTOR = (1 << SLOT_W) - 1;

    localparam logic [31:0] HEADER_BASE = 32'h7056_3412;
    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
    localparam logic [3:0]  LAST_HEADER = 4'hF;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = 3;
    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        ACT_RESCAN = 2'd0,
        ACT_SAVE   = 2'd1,
        ACT_READ   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_DONE   = 2'd3
    } kind_t;

    typedef struct packed {
        action_t            action;
        logic signed [23:0] temperature;
        logic [31:0]        read_data;
    } in_item_t;

    typedef struct packed {
        kind_t        kind;
        logic [23:0]  address;
        logic [31:0]  write_data;
        logic         accepted;
        logic         full_res;
        logic [15:0]  record_count;
        logic         last;
    } out_item_t;

endpackage

@@ hdl/flash_log_append_controller.sv @@
`timescale 1ns / 1ps

// Channel   Signals                      Direction   Payload
// req       req_valid, req_stall, req    in          flac_pkg::in_item_t
// rsp       rsp_valid, rsp_stall, rsp    out         flac_pkg::out_item_t
//
// An item is decoded in the cycle it is accepted; its zero to three results enter
// a four-entry result queue and leave from its head, one per cycle while rsp_stall
// is low, from the next cycle on. One item per cycle is taken while each gives at
// most one result and rsp is free. req_stall is high while more than one result is
// queued, so an accepted save (two results, three at a sector crossing) stalls req.
// Reset clears the queue and all scan state; free position and count read 0.

module flash_log_append_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  flac_pkg::in_item_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output flac_pkg::out_item_t  rsp
);

    logic                              scanning_reg, scanning_next;
    logic [3:0]                        header_reg, header_next;
    logic [flac_pkg::SECTOR_W-1:0]     sector_reg, sector_next;
    logic                              in_records_reg, in_records_next;
    logic [flac_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [flac_pkg::FLASH_LOG2-1:0]   free_pos_reg, free_pos_next;
    logic                              full_reg, full_next;
    logic [15:0]                       count_reg, count_next;

    flac_pkg::out_item_t               queue_reg [flac_pkg::QUEUE_DEPTH];
    flac_pkg::out_item_t               queue_next [flac_pkg::QUEUE_DEPTH];
    logic [flac_pkg::QCNT_W-1:0]       qcnt_reg, qcnt_next;

    flac_pkg::out_item_t               res [flac_pkg::MAX_RESULTS];
    logic [1:0]                        n_res;

    logic                              push, pop;
    logic [flac_pkg::QCNT_W-1:0]       base;

    logic [flac_pkg::SLOT_W-1:0]       slot_inc;
    logic [flac_pkg::SECTOR_W-1:0]     sector_inc;
    logic [15:0]                       count_inc;
    logic [31:0]                       header_word;
    logic signed [24:0]                t_adj;
    logic signed [24:0]                t_quot;
    logic [15:0]                       t_sat;
    logic [flac_pkg::FLASH_LOG2-1:0]   free_pos_inc;

    assign req_stall = (qcnt_reg > flac_pkg::QCNT_W'(1));
    assign push      = req_valid && !req_stall;
    assign rsp_valid = (qcnt_reg != '0);
    assign rsp       = queue_reg[0];
    assign pop       = rsp_valid && !rsp_stall;

    assign slot_inc     = slot_reg + 1'b1;
    assign sector_inc   = sector_reg + 1'b1;
    assign count_inc    = count_reg + 16'd1;
    assign header_word  = flac_pkg::HEADER_BASE | {4'd0, header_reg, 24'd0};
    assign free_pos_inc = free_pos_reg + flac_pkg::FLASH_LOG2'(4);

    // divide by 16, rounding toward zero, then clamp to 16 bits
    assign t_adj  = $signed({req.temperature[23], req.temperature})
                    + (req.temperature[23] ? 25'sd15 : 25'sd0);
    assign t_quot = t_adj >>> 4;
    always_comb
    begin
        if (t_quot > 25'sd32767)
            t_sat = 16'h7FFF;
        else if (t_quot < -25'sd32768)
            t_sat = 16'h8000;
        else
            t_sat = t_quot[15:0];
    end

    always_comb
    begin
        scanning_next   = scanning_reg;
        header_next     = header_reg;
        sector_next     = sector_reg;
        in_records_next = in_records_reg;
        slot_next       = slot_reg;
        free_pos_next   = free_pos_reg;
        full_next       = full_reg;
        count_next      = count_reg;
        n_res           = 2'd0;
        for (int k = 0; k < flac_pkg::MAX_RESULTS; k++)
        begin
            res[k] = '{kind: flac_pkg::KIND_READ, address: '0, write_data: '0,
                       accepted: 1'b0, full_res: full_reg, record_count: count_reg,
                       last: 1'b0};
        end

        case (req.action)
            flac_pkg::ACT_RESCAN:
            begin
                count_next      = '0;
                scanning_next   = 1'b1;
                header_next     = '0;
                sector_next     = '0;
                in_records_next = 1'b0;
                slot_next       = '0;
                res[0].record_count = '0;
                res[0].last     = 1'b1;
                n_res           = 2'd1;
            end
            flac_pkg::ACT_SAVE:
            begin
                if (full_reg || scanning_reg)
                begin
                    res[0].kind = flac_pkg::KIND_STATUS;
                    res[0].last = 1'b1;
                    n_res       = 2'd1;
                end
                else
                begin
                    count_next          = count_inc;
                    res[0].kind         = flac_pkg::KIND_WRITE;
                    res[0].address      = free_pos_reg;
                    res[0].write_data   = {count_inc[7:0], count_inc[15:8], t_sat};
                    res[0].record_count = count_inc;
                    free_pos_next       = free_pos_inc;
                    if (free_pos_inc[flac_pkg::SECTOR_LOG2-1:0] == '0)
                    begin
                        // sector filled: start a fresh scan
                        count_next          = '0;
                        scanning_next       = 1'b1;
                        header_next         = '0;
                        sector_next         = '0;
                        in_records_next     = 1'b0;
                        slot_next           = '0;
                        res[1].record_count = '0;
                        res[2].kind         = flac_pkg::KIND_STATUS;
                        res[2].accepted     = 1'b1;
                        res[2].record_count = '0;
                        res[2].last         = 1'b1;
                        n_res               = 2'd3;
                    end
                    else
                    begin
                        res[1].kind         = flac_pkg::KIND_STATUS;
                        res[1].accepted     = 1'b1;
                        res[1].record_count = count_inc;
                        res[1].last         = 1'b1;
                        n_res               = 2'd2;
                    end
                end
            end
            flac_pkg::ACT_READ:
            begin
                if (scanning_reg)
                begin
                    n_res       = 2'd1;
                    res[0].last = 1'b1;
                    if (!in_records_reg && req.read_data == header_word)
                    begin
                        in_records_next = 1'b1;
                        slot_next       = '0;
                        res[0].address  = {sector_reg, flac_pkg::SLOT_W'(1), 2'b00};
                    end
                    else if (in_records_reg && req.read_data == flac_pkg::ERASED_WORD)
                    begin
                        free_pos_next   = {sector_reg, slot_inc, 2'b00};
                        full_next       = 1'b0;
                        scanning_next   = 1'b0;
                        in_records_next = 1'b0;
                        res[0].kind     = flac_pkg::KIND_DONE;
                        res[0].address  = {sector_reg, slot_inc, 2'b00};
                        res[0].full_res = 1'b0;
                    end
                    else if (in_records_reg && (32'(slot_inc) < 32'(flac_pkg::SLOTS_PER_SECTOR)))
                    begin
                        count_next          = count_inc;
                        slot_next           = slot_inc;
                        res[0].record_count = count_inc;
                        res[0].address      = {sector_reg, slot_inc + 1'b1, 2'b00};
                    end
                    else
                    begin
                        // header mismatch or sector full: move to the next sector
                        if (in_records_reg)
                        begin
                            count_next          = count_inc;
                            res[0].record_count = count_inc;
                        end
                        in_records_next = 1'b0;
                        slot_next       = '0;
                        sector_next     = sector_inc;
                        res[0].address  = {sector_inc, flac_pkg::SECTOR_LOG2'(0)};
                        if (sector_inc == '0)
                        begin
                            if (header_reg == flac_pkg::LAST_HEADER)
                            begin
                                scanning_next   = 1'b0;
                                full_next       = 1'b1;
                                res[0].kind     = flac_pkg::KIND_DONE;
                                res[0].address  = '0;
                                res[0].full_res = 1'b1;
                            end
                            else
                            begin
                                header_next = header_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
    end

    // result queue: head at entry 0, new results appended behind the survivors
    always_comb
    begin
        base = qcnt_reg - flac_pkg::QCNT_W'(pop);
        for (int i = 0; i < flac_pkg::QUEUE_DEPTH; i++)
        begin
            if (pop && i < flac_pkg::QUEUE_DEPTH - 1)
                queue_next[i] = queue_reg[i + 1];
            else
                queue_next[i] = queue_reg[i];
            for (int k = 0; k < flac_pkg::MAX_RESULTS; k++)
            begin
                if (push && (k < 32'(n_res)) && (32'(i) == 32'(base) + k))
                    queue_next[i] = res[k];
            end
        end
        qcnt_next = base + (push ? flac_pkg::QCNT_W'(n_res) : '0);
    end

    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcnt_reg       <= '0;
            scanning_reg   <= 1'b0;
            header_reg     <= '0;
            sector_reg     <= '0;
            in_records_reg <= 1'b0;
            slot_reg       <= '0;
            free_pos_reg   <= '0;
            full_reg       <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            qcnt_reg <= qcnt_next;
            if (push)
            begin
                scanning_reg   <= scanning_next;
                header_reg     <= header_next;
                sector_reg     <= sector_next;
                in_records_reg <= in_records_next;
                slot_reg       <= slot_next;
                free_pos_reg   <= free_pos_next;
                full_reg       <= full_next;
                count_reg      <= count_next;
            end
        end
    end

endmodule

@@ tb/sv/flash_log_append_controller_test.sv @@
`timescale 1ns / 1ps

package flac_test_pkg;

    import flac_pkg::*;

    // the one action code the block has no use for
    localparam action_t ACT_SPARE = action_t'(2'd3);

    class record_log_scoreboard;

        bit          scanning;
        logic [3:0]  header_idx;
        logic [11:0] sector;
        bit          in_records;
        logic [9:0]  slot;
        logic [23:0] free_pos;
        bit          log_full;
        logic [15:0] count;
        out_item_t   expected_q[$];
        int          errors;

        function new();
            scanning   = 1'b0;
            header_idx = '0;
            sector     = '0;
            in_records = 1'b0;
            slot       = '0;
            free_pos   = '0;
            log_full   = 1'b0;
            count      = '0;
            errors     = 0;
        endfunction

        function void push(kind_t k, logic [23:0] addr, logic [31:0] data, logic acc);
            out_item_t r;
            r.kind         = k;
            r.address      = addr;
            r.write_data   = data;
            r.accepted     = acc;
            r.full_res     = log_full;
            r.record_count = count;
            r.last         = 1'b0;
            expected_q.push_back(r);
        endfunction

        function logic [23:0] sector_base();
            return {sector, 12'd0};
        endfunction

        function logic [23:0] slot_addr();
            return sector_base() + 24'd4 + {12'd0, slot, 2'b00};
        endfunction

        function void start_scan();
            count      = '0;
            scanning   = 1'b1;
            header_idx = '0;
            sector     = '0;
            in_records = 1'b0;
            slot       = '0;
            push(KIND_READ, '0, '0, 1'b0);
        endfunction

        function void next_sector();
            in_records = 1'b0;
            slot       = '0;
            if (sector == 12'hFFF)
            begin
                sector = '0;
                if (header_idx == LAST_HEADER)
                begin
                    scanning = 1'b0;
                    log_full = 1'b1;
                    push(KIND_DONE, '0, '0, 1'b0);
                    return;
                end
                header_idx = header_idx + 4'd1;
            end
            else
            begin
                sector = sector + 12'd1;
            end
            push(KIND_READ, sector_base(), '0, 1'b0);
        endfunction

        function void take_word(logic [31:0] word);
            if (!in_records)
            begin
                if (word == (HEADER_BASE | {header_idx, 24'd0}))
                begin
                    in_records = 1'b1;
                    slot       = '0;
                    push(KIND_READ, slot_addr(), '0, 1'b0);
                end
                else
                begin
                    next_sector();
                end
                return;
            end
            if (word == ERASED_WORD)
            begin
                free_pos   = slot_addr();
                log_full   = 1'b0;
                scanning   = 1'b0;
                in_records = 1'b0;
                push(KIND_DONE, free_pos, '0, 1'b0);
                return;
            end
            count = count + 16'd1;
            slot  = slot + 10'd1;
            if (slot == SLOTS_PER_SECTOR)
                next_sector();
            else
                push(KIND_READ, slot_addr(), '0, 1'b0);
        endfunction

        function void save(logic [23:0] temp_raw);
            int          t;
            int          q;
            logic [15:0] tb;
            logic [31:0] word;
            if (log_full || scanning)
            begin
                push(KIND_STATUS, '0, '0, 1'b0);
                return;
            end
            count = count + 16'd1;
            t = $signed({{8{temp_raw[23]}}, temp_raw});
            q = t / 16;
            if (q > 32767)
                q = 32767;
            else if (q < -32768)
                q = -32768;
            tb   = q[15:0];
            word = {count[7:0], count[15:8], tb[15:8], tb[7:0]};
            push(KIND_WRITE, free_pos, word, 1'b0);
            free_pos = free_pos + 24'd4;
            // crossing into a new sector (or wrapping to 0) forces a rescan
            if (free_pos[11:0] == 12'd0)
                start_scan();
            push(KIND_STATUS, '0, '0, 1'b1);
        endfunction

        // returns how many results the item causes
        function int note_request(in_item_t it);
            int queued_at_start;
            queued_at_start = expected_q.size();
            case (it.action)
                ACT_RESCAN: start_scan();
                ACT_SAVE:   save(it.temperature);
                ACT_READ:   if (scanning) take_word(it.read_data);
                default:    ;
            endcase
            if (expected_q.size() > queued_at_start)
                expected_q[expected_q.size() - 1].last = 1'b1;
            return expected_q.size() - queued_at_start;
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, kind %0d address %h",
                         $time, got.kind, got.address);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                flag("kind", 32'(want.kind), 32'(got.kind));
            if (got.address !== want.address)
                flag("address", 32'(want.address), 32'(got.address));
            if (got.write_data !== want.write_data)
                flag("write_data", want.write_data, got.write_data);
            if (got.accepted !== want.accepted)
                flag("accepted", 32'(want.accepted), 32'(got.accepted));
            if (got.full_res !== want.full_res)
                flag("full_res", 32'(want.full_res), 32'(got.full_res));
            if (got.record_count !== want.record_count)
                flag("record_count", 32'(want.record_count), 32'(got.record_count));
            if (got.last !== want.last)
                flag("last", 32'(want.last), 32'(got.last));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

    endclass

endpackage

module flash_log_append_controller_test;

    import flac_pkg::*;
    import flac_test_pkg::*;

    localparam int          RANDOM_ITEMS = 400;
    localparam int          HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 2000000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    in_item_t  req;
    logic      rsp_valid;
    logic      rsp_stall;
    out_item_t rsp;

    bit          holding    = 1'b0;
    bit          hold_armed = 1'b0;
    bit          hold_done  = 1'b0;
    int          hold_left  = 0;
    int          last_results;
    int unsigned cycles     = 0;

    record_log_scoreboard sb = new();

    flash_log_append_controller i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("flash_log_append_controller test failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic in_item_t item_of(action_t a, logic [23:0] t, logic [31:0] d);
        in_item_t it;
        it.action      = a;
        it.temperature = t;
        it.read_data   = d;
        return it;
    endfunction

    function automatic logic [23:0] rand_temp();
        logic [23:0] t;
        if ($urandom_range(0, 1) == 1)
            t = 24'($urandom());
        else
            t = 24'($urandom_range(0, 16'hFFFF) - 32768);
        return t;
    endfunction

    function automatic logic [31:0] header_word();
        return HEADER_BASE | {sb.header_idx, 24'd0};
    endfunction

    // anything but the header expected for the current index
    function automatic logic [31:0] stray_word();
        logic [31:0] w;
        if ($urandom_range(0, 7) == 0)
            w = HEADER_BASE | {sb.header_idx + 4'd1, 24'd0};
        else
            w = $urandom();
        if (w == header_word())
            w = ~w;
        return w;
    endfunction

    function automatic logic [31:0] used_word();
        logic [31:0] w;
        w = $urandom();
        if (w == ERASED_WORD)
            w = '0;
        return w;
    endfunction

    function automatic in_item_t random_item();
        int          pick;
        logic [31:0] w;
        pick = $urandom_range(0, 99);
        if (sb.scanning)
        begin
            if (pick < 3)
                return item_of(ACT_RESCAN, rand_temp(), $urandom());
            if (pick < 7)
                return item_of(ACT_SAVE, rand_temp(), $urandom());
            if (pick < 9)
                return item_of(ACT_SPARE, rand_temp(), $urandom());
            if (!sb.in_records)
                w = ($urandom_range(0, 9) < 6) ? header_word() : stray_word();
            else
                w = ($urandom_range(0, 5) == 0) ? ERASED_WORD : used_word();
            return item_of(ACT_READ, rand_temp(), w);
        end
        if (pick < 60)
            return item_of(ACT_SAVE, rand_temp(), $urandom());
        if (pick < 78)
            return item_of(ACT_RESCAN, rand_temp(), $urandom());
        if (pick < 90)
            return item_of(ACT_READ, rand_temp(), $urandom());
        return item_of(ACT_SPARE, rand_temp(), $urandom());
    endfunction

    task automatic send_item(input in_item_t item);
        int gap;
        gap = holding ? 0 : draw_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        last_results = sb.note_request(item);
    endtask

    task automatic send(input action_t a, input logic [23:0] t, input logic [31:0] d);
        send_item(item_of(a, t, d));
    endtask

    // response side: checks each item taken and may stall between items
    initial
    begin : rsp_side
        int stall_left;
        stall_left = 0;
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                sb.check_result(rsp);
                stall_left = draw_gap();
            end
            if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
                hold_left--;
            holding = (hold_left > 0);
            rsp_stall <= (hold_left > 0) || (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin : stimulus
        int random_taken;
        random_taken = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any scan: free position is 0
        send(ACT_SAVE, 24'h000000, 32'h0);
        send(ACT_READ, 24'h000000, 32'hFFFF_FFFF);
        send(ACT_SPARE, 24'hFFFFFF, 32'hFFFF_FFFF);
        // conversion: saturation at both ends, truncation toward zero
        send(ACT_SAVE, 24'h7FFFFF, 32'h0);
        send(ACT_SAVE, 24'h800000, 32'h0);
        send(ACT_SAVE, 24'hFFFFFF, 32'h0);
        send(ACT_SAVE, 24'hFFFFEF, 32'h0);
        send(ACT_SAVE, 24'h00000F, 32'h0);
        send(ACT_SAVE, 24'h000010, 32'h0);
        send(ACT_SAVE, 24'h07FFFF, 32'h0);
        send(ACT_SAVE, 24'hF80000, 32'h0);
        send(ACT_SAVE, 24'hF7FFF0, 32'h0);
        // scan with a refused save and a restart in the middle
        send(ACT_RESCAN, 24'h0, 32'h0);
        send(ACT_SAVE, 24'h000100, 32'h0);
        send(ACT_READ, 24'h0, 32'h0000_0000);
        send(ACT_RESCAN, 24'h0, 32'h0);
        send(ACT_READ, 24'h0, header_word());
        send(ACT_READ, 24'h0, 32'h0000_0000);
        send(ACT_READ, 24'h0, 32'h1234_5678);
        send(ACT_READ, 24'h0, ERASED_WORD);
        send(ACT_SAVE, 24'h000100, 32'h0);

        while (random_taken < RANDOM_ITEMS)
        begin
            send_item(random_item());
            if (last_results > 0)
                random_taken++;
            if (random_taken == 60)
                hold_armed = 1'b1;
        end
        req_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("flash_log_append_controller test passed");
        else
            $display("flash_log_append_controller test failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/flac_pkg.sv
hdl/flash_log_append_controller.sv
tb/sv/flash_log_append_controller_test.sv
